FILE: src/tksd_pkg.sv
// ----------------------------------------------------------------------------
// Terminal key sequence decoder package
// Shared types and constants for the decoder core and its top level.
// ----------------------------------------------------------------------------
package tksd_pkg;

  localparam logic [7:0] BYTE_NUL     = 8'd0;
  localparam logic [7:0] BYTE_CTRL_C  = 8'd3;
  localparam logic [7:0] BYTE_BS      = 8'd8;
  localparam logic [7:0] BYTE_LF      = 8'd10;
  localparam logic [7:0] BYTE_CR      = 8'd13;
  localparam logic [7:0] BYTE_CTRL_Z  = 8'd26;
  localparam logic [7:0] BYTE_ESC     = 8'd27;
  localparam logic [7:0] BYTE_SPACE   = 8'd32;
  localparam logic [7:0] BYTE_DEL     = 8'd127;
  localparam logic [7:0] BYTE_LBRACK  = 8'h5B;
  localparam logic [7:0] BYTE_TILDE   = 8'h7E;
  localparam logic [7:0] BYTE_UP_A    = 8'h41;
  localparam logic [7:0] BYTE_UP_B    = 8'h42;
  localparam logic [7:0] BYTE_UP_C    = 8'h43;
  localparam logic [7:0] BYTE_UP_D    = 8'h44;
  localparam logic [7:0] BYTE_UP_F    = 8'h46;
  localparam logic [7:0] BYTE_UP_H    = 8'h48;
  localparam logic [7:0] BYTE_UP_J    = 8'h4A;
  localparam logic [7:0] BYTE_DIGIT_1 = 8'h31;
  localparam logic [7:0] BYTE_DIGIT_3 = 8'h33;
  localparam logic [7:0] BYTE_DIGIT_4 = 8'h34;
  localparam logic [7:0] UTF8_LEAD2   = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3   = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4   = 8'hF0;
  localparam logic [7:0] UTF8_BAD     = 8'hF8;

  localparam logic [1:0] DIGIT_HOME   = 2'd0;
  localparam logic [1:0] DIGIT_END    = 2'd1;
  localparam logic [1:0] DIGIT_DELETE = 2'd2;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_ESC     = 6'b000010,
    PH_CSI     = 6'b000100,
    PH_TILDE   = 6'b001000,
    PH_UTF8    = 6'b010000,
    PH_DISCARD = 6'b100000
  } phase_t;

  typedef enum logic [3:0] {
    EV_CHAR      = 4'd0,
    EV_ESCAPE    = 4'd1,
    EV_UP        = 4'd2,
    EV_DOWN      = 4'd3,
    EV_LEFT      = 4'd4,
    EV_RIGHT     = 4'd5,
    EV_HOME      = 4'd6,
    EV_END       = 4'd7,
    EV_DELETE    = 4'd8,
    EV_CLEAR     = 4'd9,
    EV_BACKSPACE = 4'd10,
    EV_NEWLINE   = 4'd11,
    EV_CTRL      = 4'd12,
    EV_UNREC     = 4'd13,
    EV_CTRLC     = 4'd14
  } event_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  csi_digit;
    logic [1:0]  utf8_remaining;
    logic [31:0] utf8_collected;
    logic [2:0]  utf8_total;
    logic        swallow_lf;
  } dec_state_t;

  typedef struct packed {
    logic        valid;
    event_t      code;
    logic [4:0]  letter;
    logic [31:0] bytes;
    logic [2:0]  len;
  } dec_event_t;

endpackage

FILE: src/terminal_key_sequence_decoder.sv
// ----------------------------------------------------------------------------
// Terminal key sequence decoder
// Turns raw terminal bytes into key events: characters, cursor keys, editing
// keys, newline, escape, control letters and error events.
//
//   Channel  Signals                                                              Direction
//   in       in_valid, in_ready, key_byte, chunk_end                              sink
//   out      out_valid, out_ready, event_code, ctrl_letter, char_bytes, char_len  source
//
// One input beat is taken per cycle while in_ready is high. The decoder state
// and the result register update in the cycle of acceptance, so a key event
// appears on the out channel in the cycle after its deciding byte is accepted.
// Input stalls only while a result waits and out_ready is low. Reset is
// synchronous and returns the parser to idle with no result pending.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  key_byte,
  input  logic        chunk_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  event_code,
  output logic [4:0]  ctrl_letter,
  output logic [31:0] char_bytes,
  output logic [2:0]  char_len
);

  tksd_pkg::dec_state_t state;
  tksd_pkg::dec_state_t state_next;
  tksd_pkg::dec_event_t event_next;
  logic                 in_fire;

  tksd_decode u_decode (
    .state      (state),
    .key_byte   (key_byte),
    .chunk_end  (chunk_end),
    .state_next (state_next),
    .event_out  (event_next)
  );

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase          <= tksd_pkg::PH_IDLE;
      state.csi_digit      <= 2'd0;
      state.utf8_remaining <= 2'd0;
      state.utf8_collected <= 32'd0;
      state.utf8_total     <= 3'd0;
      state.swallow_lf     <= 1'b0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= event_next.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && event_next.valid) begin
      event_code  <= event_next.code;
      ctrl_letter <= event_next.letter;
      char_bytes  <= event_next.bytes;
      char_len    <= event_next.len;
    end
  end

endmodule

FILE: src/tksd_decode.sv
// ----------------------------------------------------------------------------
// Terminal key sequence decoder core
// Next-state and key event logic for one received byte.
// ----------------------------------------------------------------------------
module tksd_decode (
  input  tksd_pkg::dec_state_t state,
  input  logic [7:0]           key_byte,
  input  logic                 chunk_end,
  output tksd_pkg::dec_state_t state_next,
  output tksd_pkg::dec_event_t event_out
);

  always_comb begin
    logic [2:0] size;
    size       = 3'd1;
    state_next = state;
    event_out  = '{valid: 1'b0, code: tksd_pkg::EV_CHAR, letter: 5'd0,
                   bytes: 32'd0, len: 3'd0};
    case (state.phase)
      tksd_pkg::PH_DISCARD: begin
        if (chunk_end) begin
          state_next.phase = tksd_pkg::PH_IDLE;
        end
      end
      tksd_pkg::PH_ESC: begin
        state_next.phase = tksd_pkg::PH_IDLE;
        if (key_byte == tksd_pkg::BYTE_LBRACK && !chunk_end) begin
          state_next.phase = tksd_pkg::PH_CSI;
        end else if (key_byte == tksd_pkg::BYTE_UP_H) begin
          event_out.valid = 1'b1;
          event_out.code  = tksd_pkg::EV_HOME;
        end else if (key_byte == tksd_pkg::BYTE_UP_F) begin
          event_out.valid = 1'b1;
          event_out.code  = tksd_pkg::EV_END;
        end else begin
          event_out.valid  = 1'b1;
          event_out.code   = tksd_pkg::EV_UNREC;
          state_next.phase = chunk_end ? tksd_pkg::PH_IDLE : tksd_pkg::PH_DISCARD;
        end
      end
      tksd_pkg::PH_CSI: begin
        state_next.phase = tksd_pkg::PH_IDLE;
        event_out.valid  = 1'b1;
        case (key_byte)
          tksd_pkg::BYTE_UP_A: event_out.code = tksd_pkg::EV_UP;
          tksd_pkg::BYTE_UP_B: event_out.code = tksd_pkg::EV_DOWN;
          tksd_pkg::BYTE_UP_D: event_out.code = tksd_pkg::EV_LEFT;
          tksd_pkg::BYTE_UP_C: event_out.code = tksd_pkg::EV_RIGHT;
          tksd_pkg::BYTE_UP_H: event_out.code = tksd_pkg::EV_HOME;
          tksd_pkg::BYTE_UP_F: event_out.code = tksd_pkg::EV_END;
          tksd_pkg::BYTE_UP_J: event_out.code = tksd_pkg::EV_CLEAR;
          tksd_pkg::BYTE_DIGIT_1, tksd_pkg::BYTE_DIGIT_3, tksd_pkg::BYTE_DIGIT_4: begin
            if (chunk_end) begin
              event_out.code = tksd_pkg::EV_UNREC;
            end else begin
              event_out.valid  = 1'b0;
              state_next.phase = tksd_pkg::PH_TILDE;
              if (key_byte == tksd_pkg::BYTE_DIGIT_1) begin
                state_next.csi_digit = tksd_pkg::DIGIT_HOME;
              end else if (key_byte == tksd_pkg::BYTE_DIGIT_4) begin
                state_next.csi_digit = tksd_pkg::DIGIT_END;
              end else begin
                state_next.csi_digit = tksd_pkg::DIGIT_DELETE;
              end
            end
          end
          default: begin
            event_out.code   = tksd_pkg::EV_UNREC;
            state_next.phase = chunk_end ? tksd_pkg::PH_IDLE : tksd_pkg::PH_DISCARD;
          end
        endcase
      end
      tksd_pkg::PH_TILDE: begin
        state_next.phase = tksd_pkg::PH_IDLE;
        event_out.valid  = 1'b1;
        if (key_byte == tksd_pkg::BYTE_TILDE) begin
          case (state.csi_digit)
            tksd_pkg::DIGIT_HOME: event_out.code = tksd_pkg::EV_HOME;
            tksd_pkg::DIGIT_END:  event_out.code = tksd_pkg::EV_END;
            default:              event_out.code = tksd_pkg::EV_DELETE;
          endcase
        end else begin
          event_out.code   = tksd_pkg::EV_UNREC;
          state_next.phase = chunk_end ? tksd_pkg::PH_IDLE : tksd_pkg::PH_DISCARD;
        end
      end
      tksd_pkg::PH_UTF8: begin
        state_next.utf8_collected = {state.utf8_collected[23:0], key_byte};
        if (state.utf8_remaining <= 2'd1) begin
          state_next.utf8_remaining = 2'd0;
          state_next.phase          = tksd_pkg::PH_IDLE;
          event_out.valid = 1'b1;
          event_out.code  = tksd_pkg::EV_CHAR;
          event_out.bytes = {state.utf8_collected[23:0], key_byte};
          event_out.len   = state.utf8_total;
        end else begin
          state_next.utf8_remaining = state.utf8_remaining - 2'd1;
        end
      end
      default: begin
        state_next.phase      = tksd_pkg::PH_IDLE;
        state_next.swallow_lf = 1'b0;
        if (state.swallow_lf && key_byte == tksd_pkg::BYTE_LF) begin
          event_out.valid = 1'b0;
        end else if (key_byte >= tksd_pkg::BYTE_SPACE && key_byte != tksd_pkg::BYTE_DEL) begin
          if (key_byte < tksd_pkg::UTF8_LEAD2) begin
            size = 3'd1;
          end else if (key_byte < tksd_pkg::UTF8_LEAD3) begin
            size = 3'd2;
          end else if (key_byte < tksd_pkg::UTF8_LEAD4) begin
            size = 3'd3;
          end else if (key_byte < tksd_pkg::UTF8_BAD) begin
            size = 3'd4;
          end else begin
            size = 3'd1;
          end
          if (size == 3'd1) begin
            event_out.valid = 1'b1;
            event_out.code  = tksd_pkg::EV_CHAR;
            event_out.bytes = {24'd0, key_byte};
            event_out.len   = 3'd1;
          end else begin
            state_next.utf8_collected = {24'd0, key_byte};
            state_next.utf8_total     = size;
            state_next.utf8_remaining = 2'(size - 3'd1);
            state_next.phase          = tksd_pkg::PH_UTF8;
          end
        end else if (key_byte == tksd_pkg::BYTE_ESC) begin
          if (chunk_end) begin
            event_out.valid = 1'b1;
            event_out.code  = tksd_pkg::EV_ESCAPE;
          end else begin
            state_next.phase = tksd_pkg::PH_ESC;
          end
        end else if (key_byte == tksd_pkg::BYTE_CTRL_C) begin
          event_out.valid = 1'b1;
          event_out.code  = tksd_pkg::EV_CTRLC;
        end else if (key_byte == tksd_pkg::BYTE_BS || key_byte == tksd_pkg::BYTE_DEL) begin
          event_out.valid = 1'b1;
          event_out.code  = tksd_pkg::EV_BACKSPACE;
        end else if (key_byte == tksd_pkg::BYTE_CR) begin
          state_next.swallow_lf = !chunk_end;
          event_out.valid = 1'b1;
          event_out.code  = tksd_pkg::EV_NEWLINE;
        end else if (key_byte == tksd_pkg::BYTE_LF) begin
          event_out.valid = 1'b1;
          event_out.code  = tksd_pkg::EV_NEWLINE;
        end else if (key_byte != tksd_pkg::BYTE_NUL && key_byte <= tksd_pkg::BYTE_CTRL_Z) begin
          event_out.valid  = 1'b1;
          event_out.code   = tksd_pkg::EV_CTRL;
          event_out.letter = 5'(key_byte - 8'd1);
        end else begin
          event_out.valid  = 1'b1;
          event_out.code   = tksd_pkg::EV_UNREC;
          state_next.phase = chunk_end ? tksd_pkg::PH_IDLE : tksd_pkg::PH_DISCARD;
        end
      end
    endcase
  end

endmodule
